// ===== rtl/cifpd_pkg.sv =====
package cifpd_pkg;

	// field widths
	localparam int PIX_W   = 18;
	localparam int DEPTH_W = 32;
	localparam int IDX_W   = 16;
	localparam int TILE_W  = 10;
	localparam int SLICE_W = 8;

	// configuration register widths
	localparam int TS_W    = 9;
	localparam int TCNT_W  = 11;
	localparam int SCNT_W  = 9;
	localparam int SCALE_W = 24;
	localparam int BIAS_W  = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// grid limits
	localparam logic [TCNT_W-1:0] MAX_TILES  = TCNT_W'(1024);
	localparam logic [SCNT_W-1:0] MAX_SLICES = SCNT_W'(256);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLICES      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_BIAS  = 3'd5;

	// whole-pixel coordinate after dropping the four fraction bits
	localparam int QPIX_W = PIX_W - 5;
	// log2 result: signed Q6.16
	localparam int FRAC_W = 16;
	localparam int LOG_W  = 6 + FRAC_W;
	localparam int POS_W  = 5;

	// pipeline depth
	localparam int TILE_LAT  = QPIX_W + 2;
	localparam int LOG_LAT   = FRAC_W + 1;
	localparam int SLICE_LAT = LOG_LAT + 2;
	localparam int PIPE_LAT  = SLICE_LAT + 2;

	typedef logic [TILE_W-1:0] tile_t;

endpackage

// ===== rtl/cifpd_tile_unit.sv =====
module cifpd_tile_unit (
	input  logic                           clk,
	input  logic                           en,
	input  logic [cifpd_pkg::PIX_W-1:0]    pix,
	input  logic [cifpd_pkg::TS_W-1:0]     tile_size,
	input  logic [cifpd_pkg::TCNT_W-1:0]   count,
	output cifpd_pkg::tile_t               tile
);
	import cifpd_pkg::*;

	logic [TS_W-1:0]   ts_eff;
	logic [TCNT_W-1:0] cnt_m1;

	// stage registers: index 0 is the captured input
	logic [QPIX_W-1:0] dvd_s [0:QPIX_W];
	logic [QPIX_W-1:0] quo_s [0:QPIX_W];
	logic [TS_W-1:0]   rem_s [0:QPIX_W];
	logic              neg_s [0:QPIX_W];
	tile_t             tile_q;

	assign ts_eff = (tile_size == '0) ? TS_W'(1) : tile_size;
	assign cnt_m1 = count - TCNT_W'(1);

	// capture whole-pixel dividend
	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s[0] <= pix[PIX_W-2:4];
			neg_s[0] <= pix[PIX_W-1];
			quo_s[0] <= '0;
			rem_s[0] <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QPIX_W; k++) begin : g_div
		logic [TS_W:0] trial;
		logic          ge;
		assign trial = {rem_s[k], dvd_s[k][QPIX_W-1-k]};
		assign ge    = (trial >= {1'b0, ts_eff});
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k+1] <= dvd_s[k];
				neg_s[k+1] <= neg_s[k];
				quo_s[k+1] <= {quo_s[k][QPIX_W-2:0], ge};
				rem_s[k+1] <= ge ? TS_W'(trial - {1'b0, ts_eff}) : TS_W'(trial);
			end
		end
	end

	// clamp to the grid
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QPIX_W]) begin
				tile_q <= '0;
			end else if ({1'b0, quo_s[QPIX_W]} > (QPIX_W+1)'(cnt_m1)) begin
				tile_q <= TILE_W'(cnt_m1);
			end else begin
				tile_q <= TILE_W'(quo_s[QPIX_W]);
			end
		end
	end

	assign tile = tile_q;
endmodule

// ===== rtl/cifpd_log_unit.sv =====
module cifpd_log_unit (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cifpd_pkg::DEPTH_W-1:0] depth,
	output logic [cifpd_pkg::LOG_W-1:0]   log_val
);
	import cifpd_pkg::*;

	logic [DEPTH_W-1:0] d_eff;
	logic [POS_W-1:0]   pos;

	logic [DEPTH_W-1:0] m_s    [0:FRAC_W];
	logic [FRAC_W-1:0]  frac_s [0:FRAC_W];
	logic [POS_W-1:0]   pos_s  [0:FRAC_W];

	// zero depth counts as one lsb, then leading-one detect
	always_comb begin
		d_eff = (depth == '0) ? DEPTH_W'(1) : depth;
		pos = '0;
		for (int i = 0; i < DEPTH_W; i++) begin
			if (d_eff[i]) pos = POS_W'(i);
		end
	end

	// normalize mantissa to q1.31
	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= d_eff << (POS_W'(DEPTH_W-1) - pos);
			pos_s[0]  <= pos;
			frac_s[0] <= '0;
		end
	end

	// one fraction bit per squaring stage
	for (genvar k = 0; k < FRAC_W; k++) begin : g_sq
		logic [2*DEPTH_W-1:0] sq;
		logic [DEPTH_W:0]     sq_hi;
		assign sq    = m_s[k] * m_s[k];
		assign sq_hi = sq[2*DEPTH_W-1:DEPTH_W-1];
		always_ff @(posedge clk) begin
			if (en) begin
				pos_s[k+1]  <= pos_s[k];
				frac_s[k+1] <= {frac_s[k][FRAC_W-2:0], sq_hi[DEPTH_W]};
				m_s[k+1]    <= sq_hi[DEPTH_W] ? sq_hi[DEPTH_W:1] : sq_hi[DEPTH_W-1:0];
			end
		end
	end

	// integer part is position minus the sixteen fraction bits
	assign log_val = {6'(pos_s[FRAC_W]) - 6'd16, frac_s[FRAC_W]};
endmodule

// ===== rtl/cifpd_slice_unit.sv =====
module cifpd_slice_unit (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cifpd_pkg::LOG_W-1:0]   log_val,
	input  logic [cifpd_pkg::SCALE_W-1:0] scale,
	input  logic [cifpd_pkg::BIAS_W-1:0]  bias,
	input  logic [cifpd_pkg::SCNT_W-1:0]  num_slices,
	output logic [cifpd_pkg::SLICE_W-1:0] slice
);
	import cifpd_pkg::*;

	localparam int PROD_W = LOG_W + SCALE_W + 1;
	localparam int SUM_W  = BIAS_W + 17;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]  sum;
	logic [SCNT_W-1:0]        smax;
	logic [15:0]              whole;
	logic [SLICE_W-1:0]       slice_s2;

	// scale the log value
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= $signed(log_val) * $signed({1'b0, scale});
		end
	end

	// add bias and clamp
	assign sum   = SUM_W'(prod_s1) + $signed({bias, 16'b0});
	assign smax  = num_slices - SCNT_W'(1);
	assign whole = sum[47:32];

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum[SUM_W-1]) begin
				slice_s2 <= '0;
			end else if (whole > 16'(smax)) begin
				slice_s2 <= SLICE_W'(smax);
			end else begin
				slice_s2 <= SLICE_W'(whole);
			end
		end
	end

	assign slice = slice_s2;
endmodule

// ===== rtl/cluster_index_from_pixel_depth_unit.sv =====
// cluster index from pixel position and view depth
//
// input channel: in_valid / in_stall carrying pixel_x, pixel_y (signed q13.4)
// and view_depth (unsigned q16.16). output channel: out_valid / out_stall
// carrying cluster_index, tile_column, tile_row and depth_slice.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
// always high; the user must write registers only while no transaction is in
// flight (the block does not enforce this).
//
// throughput is one transaction per cycle unless stalled; the depth is set by
// the sixteen log2 squaring stages plus scale, clamp and two index multiplies.
// the tile division runs beside the log unit, one quotient bit per stage.
//
// reset clears all valid bits and loads the register defaults. when the
// receiver stalls a valid result, the whole pipeline holds and in_stall rises
// in the same cycle; nothing is dropped or repeated.
module cluster_index_from_pixel_depth_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cifpd_pkg::PIX_W-1:0]     pixel_x,
	input  logic [cifpd_pkg::PIX_W-1:0]     pixel_y,
	input  logic [cifpd_pkg::DEPTH_W-1:0]   view_depth,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cifpd_pkg::IDX_W-1:0]     cluster_index,
	output logic [cifpd_pkg::TILE_W-1:0]    tile_column,
	output logic [cifpd_pkg::TILE_W-1:0]    tile_row,
	output logic [cifpd_pkg::SLICE_W-1:0]   depth_slice,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cifpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cifpd_pkg::CFG_DAT_W-1:0] cfg_data
);
	import cifpd_pkg::*;

	logic [TS_W-1:0]    tile_size_q;
	logic [TCNT_W-1:0]  tiles_x_q;
	logic [TCNT_W-1:0]  tiles_y_q;
	logic [SCNT_W-1:0]  slices_q;
	logic [SCALE_W-1:0] scale_q;
	logic [BIAS_W-1:0]  bias_q;

	logic [TCNT_W-1:0]  tx_eff;
	logic [TCNT_W-1:0]  ty_eff;
	logic [SCNT_W-1:0]  ns_eff;

	logic               en;
	logic [PIPE_LAT:1]  valid_s;

	tile_t              col_unit;
	tile_t              row_unit;
	logic [LOG_W-1:0]   log_val;
	logic [SLICE_W-1:0] slice_unit;

	tile_t              col_s [TILE_LAT+1:PIPE_LAT];
	tile_t              row_s [TILE_LAT+1:PIPE_LAT];
	logic [SLICE_W-1:0] slice_s20;
	logic [SLICE_W-1:0] slice_s21;
	logic [19:0]        lin_s20;
	logic [30:0]        idx_full;
	logic [IDX_W-1:0]   idx_s21;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q <= TS_W'(16);
			tiles_x_q   <= TCNT_W'(1);
			tiles_y_q   <= TCNT_W'(1);
			slices_q    <= SCNT_W'(1);
			scale_q     <= SCALE_W'(65536);
			bias_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TILE_SIZE:   tile_size_q <= cfg_data[TS_W-1:0];
				REG_TILES_X:     tiles_x_q   <= cfg_data[TCNT_W-1:0];
				REG_TILES_Y:     tiles_y_q   <= cfg_data[TCNT_W-1:0];
				REG_SLICES:      slices_q    <= cfg_data[SCNT_W-1:0];
				REG_SLICE_SCALE: scale_q     <= cfg_data[SCALE_W-1:0];
				REG_SLICE_BIAS:  bias_q      <= cfg_data[BIAS_W-1:0];
				default: ;
			endcase
		end
	end

	// grid counts, zero taken as one, capped at the limits
	assign tx_eff = (tiles_x_q == '0) ? TCNT_W'(1) :
		(tiles_x_q > MAX_TILES) ? MAX_TILES : tiles_x_q;
	assign ty_eff = (tiles_y_q == '0) ? TCNT_W'(1) :
		(tiles_y_q > MAX_TILES) ? MAX_TILES : tiles_y_q;
	assign ns_eff = (slices_q == '0) ? SCNT_W'(1) :
		(slices_q > MAX_SLICES) ? MAX_SLICES : slices_q;

	// pipeline advance and valid bits
	assign en       = !(valid_s[PIPE_LAT] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[PIPE_LAT-1:1], in_valid};
		end
	end

	cifpd_tile_unit u_col (
		.clk       (clk),
		.en        (en),
		.pix       (pixel_x),
		.tile_size (tile_size_q),
		.count     (tx_eff),
		.tile      (col_unit)
	);

	cifpd_tile_unit u_row (
		.clk       (clk),
		.en        (en),
		.pix       (pixel_y),
		.tile_size (tile_size_q),
		.count     (ty_eff),
		.tile      (row_unit)
	);

	cifpd_log_unit u_log (
		.clk     (clk),
		.en      (en),
		.depth   (view_depth),
		.log_val (log_val)
	);

	cifpd_slice_unit u_slice (
		.clk        (clk),
		.en         (en),
		.log_val    (log_val),
		.scale      (scale_q),
		.bias       (bias_q),
		.num_slices (ns_eff),
		.slice      (slice_unit)
	);

	// carry tiles along to the index stages
	for (genvar i = TILE_LAT + 1; i <= PIPE_LAT; i++) begin : g_dly
		if (i == TILE_LAT + 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					col_s[i] <= col_unit;
					row_s[i] <= row_unit;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					col_s[i] <= col_s[i-1];
					row_s[i] <= row_s[i-1];
				end
			end
		end
	end

	// linear index: slice-major, then row, then column
	assign idx_full = 31'(lin_s20) * 31'(tx_eff) + 31'(col_s[PIPE_LAT-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s20   <= 20'(slice_unit) * 20'(ty_eff) + 20'(row_s[SLICE_LAT]);
			slice_s20 <= slice_unit;
			slice_s21 <= slice_s20;
			idx_s21   <= idx_full[IDX_W-1:0];
		end
	end

	assign out_valid     = valid_s[PIPE_LAT];
	assign cluster_index = idx_s21;
	assign tile_column   = col_s[PIPE_LAT];
	assign tile_row      = row_s[PIPE_LAT];
	assign depth_slice   = slice_s21;
endmodule

// ===== rtl/cifpd_checker.sv =====
module cifpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        cfg_ready,
	input logic [15:0] cluster_index,
	input logic [9:0]  tile_column
);
	// input side stalls exactly when a result is held back
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow output backpressure");

	// a held result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cluster_index)
		&& $stable(tile_column))
		else $error("stalled result changed");

	// config port always open
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");
endmodule

bind cluster_index_from_pixel_depth_unit cifpd_checker u_cifpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cfg_ready     (cfg_ready),
	.cluster_index (cluster_index),
	.tile_column   (tile_column)
);

// ===== tb/sv/cluster_index_from_pixel_depth_unit_tb.sv =====
module cluster_index_from_pixel_depth_unit_tb;
	import cifpd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic [DEPTH_W-1:0] depth;
	} fragment_t;

	typedef struct packed {
		logic [IDX_W-1:0]   index;
		logic [TILE_W-1:0]  col;
		logic [TILE_W-1:0]  row;
		logic [SLICE_W-1:0] slice;
	} cluster_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] pixel_x = '0;
	logic [PIX_W-1:0] pixel_y = '0;
	logic [DEPTH_W-1:0] view_depth = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [IDX_W-1:0] cluster_index;
	logic [TILE_W-1:0] tile_column;
	logic [TILE_W-1:0] tile_row;
	logic [SLICE_W-1:0] depth_slice;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// shadow copy of the grid registers
	logic [TS_W-1:0]    m_tile_size = 9'd16;
	logic [TCNT_W-1:0]  m_tiles_x = 11'd1;
	logic [TCNT_W-1:0]  m_tiles_y = 11'd1;
	logic [SCNT_W-1:0]  m_slices = 9'd1;
	logic [SCALE_W-1:0] m_scale = 24'd65536;
	logic [BIAS_W-1:0]  m_bias = '0;

	fragment_t pending_frags[$];
	cluster_t  expected_clusters[$];
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;

	cluster_index_from_pixel_depth_unit i_dut (.*);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] grid_count(logic [31:0] v, logic [31:0] maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic logic [31:0] tile_pos(logic [PIX_W-1:0] p, logic [31:0] cnt);
		logic [31:0] ts;
		logic [31:0] t;
		ts = (m_tile_size == 0) ? 32'd1 : 32'(m_tile_size);
		if (p[PIX_W-1]) return 0;
		t = 32'(p) / (16 * ts);
		if (t > cnt - 1) t = cnt - 1;
		return t;
	endfunction

	// fixed-point log2 by leading one and repeated squaring, signed q6.16
	function automatic longint log2_depth(logic [31:0] d);
		int p;
		logic [63:0] m;
		logic [31:0] frac;
		p = 31;
		frac = 0;
		while (p > 0 && d[p] == 1'b0) p--;
		m = (64'(d) << (31 - p)) & 64'hFFFF_FFFF;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return longint'(p - 16) * 65536 + longint'(frac);
	endfunction

	function automatic cluster_t locate_cluster(fragment_t f);
		logic [31:0] tx, ty, ns, col, row, slice, idx, d;
		longint t;
		cluster_t c;
		tx = grid_count(32'(m_tiles_x), 1024);
		ty = grid_count(32'(m_tiles_y), 1024);
		ns = grid_count(32'(m_slices), 256);
		col = tile_pos(f.px, tx);
		row = tile_pos(f.py, ty);
		d = (f.depth == 0) ? 32'd1 : f.depth;
		t = log2_depth(d) * longint'(m_scale) + longint'($signed(m_bias)) * 65536;
		if (t < 0) slice = 0;
		else if ((t >>> 32) > longint'(ns - 1)) slice = ns - 1;
		else slice = 32'(t >>> 32);
		idx = (slice * ty + row) * tx + col;
		c.index = idx[IDX_W-1:0];
		c.col = col[TILE_W-1:0];
		c.row = row[TILE_W-1:0];
		c.slice = slice[SLICE_W-1:0];
		return c;
	endfunction

	// driver: pops fragments and predicts their cluster at acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_clusters.push_back(locate_cluster({pixel_x, pixel_y, view_depth}));
			end
			if (!in_valid || !in_stall) begin
				if (pending_frags.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					fragment_t f;
					f = pending_frags.pop_front();
					in_valid <= 1'b1;
					pixel_x <= f.px;
					pixel_y <= f.py;
					view_depth <= f.depth;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			cluster_t got, want;
			got = {cluster_index, tile_column, tile_row, depth_slice};
			results_seen <= results_seen + 1;
			if (expected_clusters.size() == 0) begin
				if (mismatches < 10) $display("unexpected result %h", got);
				mismatches <= mismatches + 1;
			end else begin
				want = expected_clusters.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display("mismatch idx/col/row/slice: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
							want.index, want.col, want.row, want.slice,
							got.index, got.col, got.row, got.slice);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL cluster_index_from_pixel_depth_unit");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_frags.size() > 0 || in_valid || expected_clusters.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TILE_SIZE:   m_tile_size = val[TS_W-1:0];
			REG_TILES_X:     m_tiles_x = val[TCNT_W-1:0];
			REG_TILES_Y:     m_tiles_y = val[TCNT_W-1:0];
			REG_SLICES:      m_slices = val[SCNT_W-1:0];
			REG_SLICE_SCALE: m_scale = val[SCALE_W-1:0];
			REG_SLICE_BIAS:  m_bias = val;
			default: ;
		endcase
	endtask

	task automatic set_grid(int ts, int tx, int ty, int ns, int sc, int bi);
		write_reg(REG_TILE_SIZE, 32'(ts));
		write_reg(REG_TILES_X, 32'(tx));
		write_reg(REG_TILES_Y, 32'(ty));
		write_reg(REG_SLICES, 32'(ns));
		write_reg(REG_SLICE_SCALE, 32'(sc));
		write_reg(REG_SLICE_BIAS, 32'(bi));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic fragment_t rand_fragment();
		fragment_t f;
		f.px = PIX_W'($urandom);
		f.py = PIX_W'($urandom);
		case ($urandom_range(3))
			0: f.depth = $urandom;
			1: f.depth = $urandom >> $urandom_range(31);
			2: f.depth = 32'($urandom_range(0, 3));
			default: f.depth = 32'h1_0000 << $urandom_range(15);
		endcase
		// mostly on-screen positions
		if ($urandom_range(3) != 0) begin
			f.px[PIX_W-1] = 1'b0;
			f.py[PIX_W-1] = 1'b0;
		end
		return f;
	endfunction

	task automatic rand_grid();
		set_grid($urandom_range(0, 256), $urandom_range(0, 2047), $urandom_range(0, 2047),
			$urandom_range(0, 511), $urandom & 24'hFFFFFF, $signed($urandom) >>> $urandom_range(31));
	endtask

	initial begin
		fragment_t f;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults then extremes
		sender_idle_pct = 15;
		receiver_idle_pct = 71;
		pending_frags.push_back('{0, 0, 0});
		pending_frags.push_back('{18'h1FFFF, 18'h1FFFF, 32'hFFFF_FFFF});
		pending_frags.push_back('{18'h20000, 18'h20000, 32'h1_0000});
		wait_drained();
		set_grid(0, 0, 0, 0, 24'hFFFFFF, 32'h8000_0000);
		pending_frags.push_back('{18'h1FFFF, 18'h00000, 32'h0});
		pending_frags.push_back('{18'h0000F, 18'h3FFFF, 32'hFFFF_FFFF});
		wait_drained();
		set_grid(256, 1024, 1024, 256, 24'hFFFFFF, 32'h7FFF_FFFF);
		pending_frags.push_back('{18'h1FFFF, 18'h1FFFF, 32'h1});
		pending_frags.push_back('{18'h00100, 18'h3FFFF, 32'h8000_0000});
		wait_drained();
		set_grid(1, 2047, 2047, 511, 24'h100000, -32'sd1000000);
		for (int i = 0; i < 12; i++) begin
			f = rand_fragment();
			f.depth = 32'h1 << i * 2;
			pending_frags.push_back(f);
		end
		pending_frags.push_back('{18'h00010, 18'h00020, 32'h0001_8000});
		pending_frags.push_back('{18'h1FFF0, 18'h3FFF0, 32'h00FF_FFFF});
		wait_drained();
		set_grid(4, 64, 48, 24, 24'h30000, 32'hFFF0_0000);

		// random phases, idling swapped then none
		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 3) begin
				sender_idle_pct = 71;
				receiver_idle_pct = 15;
			end else if (phase == 6) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			for (int i = 0; i < 194; i++) pending_frags.push_back(rand_fragment());
			wait_drained();
			rand_grid();
		end

		$display("ran %0d fragment transactions across directed and random grid settings", results_seen);
		$display("with sender and receiver idling swapped between phases; %0d mismatches", mismatches);
		if (mismatches == 0 && expected_clusters.size() == 0) begin
			$display("PASS cluster_index_from_pixel_depth_unit");
		end else begin
			$display("FAIL cluster_index_from_pixel_depth_unit");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/cifpd_pkg.sv
rtl/cifpd_tile_unit.sv
rtl/cifpd_log_unit.sv
rtl/cifpd_slice_unit.sv
rtl/cluster_index_from_pixel_depth_unit.sv
rtl/cifpd_checker.sv
tb/sv/cluster_index_from_pixel_depth_unit_tb.sv
